FILE: src/iirdf1_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the direct form I IIR filter.
// No dependencies; every other file of the block imports this package.
package iirdf1_pkg;

    // Default sizes, handed to the top level parameters
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int FF_TAPS_DEF      = 4;
    localparam int FB_TAPS_DEF      = 4;

    // Coefficient format: Q3.14
    localparam int COEF_WIDTH      = 18;
    localparam int FRAC_SHIFT      = 14;
    localparam int NUM_REGS        = 8;
    localparam int REG_INDEX_WIDTH = 3;

    typedef logic signed [COEF_WIDTH-1:0] coef_t;

    // Unity gain in Q3.14
    localparam coef_t COEF_ONE = coef_t'(1 << FRAC_SHIFT);

    // Coefficient register map
    typedef enum logic [REG_INDEX_WIDTH-1:0] {
        REG_FF_COEF_0 = 3'd0,
        REG_FF_COEF_1 = 3'd1,
        REG_FF_COEF_2 = 3'd2,
        REG_FF_COEF_3 = 3'd3,
        REG_FB_COEF_1 = 3'd4,
        REG_FB_COEF_2 = 3'd5,
        REG_FB_COEF_3 = 3'd6,
        REG_FB_COEF_4 = 3'd7
    } reg_index_t;

    // Pipeline control from the handshake logic to the datapath
    typedef struct packed {
        logic load;     // input transfer: capture sample and restart flag
        logic advance;  // move captured sample into the result register
    } iirdf1_ctl_t;

endpackage

FILE: src/iirdf1_if.sv
`timescale 1ns / 1ps
// Stream interfaces for the filter: sample input channel and result channel.
// Depends on iirdf1_pkg for the default sample width.
interface iirdf1_in_if
    import iirdf1_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           restart;

    modport source (output valid, output sample_in, output restart, input ready);
    modport sink   (input valid, input sample_in, input restart, output ready);
endinterface

interface iirdf1_out_if
    import iirdf1_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

FILE: src/iir_direct_form_one_filter.sv
`timescale 1ns / 1ps
// Direct form I IIR filter top level: coefficient registers and stream handshake.
// Depends on iirdf1_pkg, iirdf1_if and iirdf1_core.

// Takes one signed Q1.15 sample per transfer and returns one rounded, saturated
// Q1.15 result per sample, y[n] = sum b_k x[n-k] - sum a_k y[n-k]. A new sample
// is accepted every clock cycle while the result side is not stalled. The sample
// register captures an item at its input transfer; when the result register is
// free or being drained, the multiply-accumulate of all products feeds the result
// register. That combinational path closes the feedback loop, so the next sample
// already sees y[n-1]. Coefficients are Q3.14 at register indexes 0 to 7 (b0..b3,
// a1..a4) and reset to a pass-through filter. The user must write them only while
// the filter is idle; the block itself does not enforce this. A sample with
// restart set clears both histories before it is filtered.
module iir_direct_form_one_filter
    import iirdf1_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int FF_TAPS      = FF_TAPS_DEF,
    parameter int FB_TAPS      = FB_TAPS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    iirdf1_in_if.sink                  din,
    iirdf1_out_if.source               dout,
    input  logic                       cfg_we,
    input  logic [REG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [COEF_WIDTH-1:0]      cfg_data
);

    coef_t       coef_reg [NUM_REGS];
    logic        s1_valid_reg;
    logic        out_valid_reg;
    iirdf1_ctl_t ctl;

    // Coefficient register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_REGS; k++)
            begin
                coef_reg[k] <= '0;
            end
            coef_reg[REG_FF_COEF_0] <= COEF_ONE;
        end
        else if (cfg_we)
        begin
            coef_reg[cfg_index] <= coef_t'(cfg_data);
        end
    end

    // Advance when the result register is free or being drained
    always_comb
    begin
        ctl.advance = s1_valid_reg && (!out_valid_reg || dout.ready);
        din.ready   = !s1_valid_reg || ctl.advance;
        ctl.load    = din.valid && din.ready;
    end

    // Track occupancy of the sample and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.load)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (ctl.advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (ctl.advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (dout.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    iirdf1_core #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FF_TAPS      (FF_TAPS),
        .FB_TAPS      (FB_TAPS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sample_in  (din.sample_in),
        .restart    (din.restart),
        .coef       (coef_reg),
        .sample_out (dout.sample_out)
    );

    assign dout.valid = out_valid_reg;

`ifndef SYNTHESIS
    // An input transfer always leaves a sample waiting in the sample register
    a_load_fills: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> s1_valid_reg)
        else $error("input transfer did not fill the sample register");

    // A waiting sample is never dropped while the result side stalls
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !dout.ready) |=> (s1_valid_reg && out_valid_reg))
        else $error("sample or result lost during output stall");

    // Input is refused only when both registers are occupied
    a_ready_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !din.ready |-> (s1_valid_reg && out_valid_reg && !dout.ready))
        else $error("input refused with room in the pipeline");

    // Each advance produces a result on the next cycle
    a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.advance |=> out_valid_reg)
        else $error("advance did not produce a result");
`endif

endmodule

FILE: src/iirdf1_core.sv
`timescale 1ns / 1ps
// Filter datapath: sample register, delay lines, eight-product sum,
// rounding, saturation and result register. Depends on iirdf1_pkg.
module iirdf1_core
    import iirdf1_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int FF_TAPS      = FF_TAPS_DEF,
    parameter int FB_TAPS      = FB_TAPS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  iirdf1_ctl_t                    ctl,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    input  logic                           restart,
    input  coef_t                          coef [NUM_REGS],
    output logic signed [SAMPLE_WIDTH-1:0] sample_out
);

    localparam int IN_HIST  = (FF_TAPS > 1) ? FF_TAPS - 1 : 1;
    localparam int OUT_HIST = (FB_TAPS > 0) ? FB_TAPS : 1;
    localparam int PROD_W   = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_W    = PROD_W + 3;
    localparam int BIAS_W   = ACC_W + 1;
    localparam int RND_W    = BIAS_W - FRAC_SHIFT;

    localparam logic signed [BIAS_W-1:0] ROUND_HALF = BIAS_W'(1 << (FRAC_SHIFT - 1));
    localparam logic signed [RND_W-1:0]  SMAX =
        {{(RND_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [RND_W-1:0]  SMIN =
        {{(RND_W - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    sample_t x_reg;
    logic    restart_reg;
    sample_t xh_reg [IN_HIST];
    sample_t yh_reg [OUT_HIST];
    sample_t y_reg;

    sample_t                   xh_eff [IN_HIST];
    sample_t                   yh_eff [OUT_HIST];
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]   acc;
    logic signed [BIAS_W-1:0]  biased;
    logic signed [RND_W-1:0]   rounded;
    sample_t                   y_next;

    // Capture the sample on an input transfer
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            x_reg       <= sample_in;
            restart_reg <= restart;
        end
    end

    // Restart zeroes both histories ahead of this sample
    always_comb
    begin
        for (int k = 0; k < IN_HIST; k++)
        begin
            xh_eff[k] = restart_reg ? '0 : xh_reg[k];
        end
        for (int k = 0; k < OUT_HIST; k++)
        begin
            yh_eff[k] = restart_reg ? '0 : yh_reg[k];
        end
    end

    // Sum the feedforward and feedback products in one pass
    always_comb
    begin
        prod = x_reg * coef[REG_FF_COEF_0];
        acc  = ACC_W'(prod);
        for (int k = 1; k < FF_TAPS; k++)
        begin
            prod = xh_eff[k-1] * coef[int'(REG_FF_COEF_0) + k];
            acc  = acc + ACC_W'(prod);
        end
        for (int k = 1; k <= FB_TAPS; k++)
        begin
            prod = yh_eff[k-1] * coef[int'(REG_FB_COEF_1) + k - 1];
            acc  = acc - ACC_W'(prod);
        end
    end

    // Round half up to Q1.15, then saturate to the sample range
    always_comb
    begin
        biased  = BIAS_W'(acc) + ROUND_HALF;
        rounded = RND_W'(biased >>> FRAC_SHIFT);
        if (rounded > SMAX)
        begin
            y_next = SMAX[SAMPLE_WIDTH-1:0];
        end
        else if (rounded < SMIN)
        begin
            y_next = SMIN[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            y_next = rounded[SAMPLE_WIDTH-1:0];
        end
    end

    // Advance the delay lines as the result is registered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < IN_HIST; k++)
            begin
                xh_reg[k] <= '0;
            end
            for (int k = 0; k < OUT_HIST; k++)
            begin
                yh_reg[k] <= '0;
            end
        end
        else if (ctl.advance)
        begin
            xh_reg[0] <= x_reg;
            for (int k = 1; k < IN_HIST; k++)
            begin
                xh_reg[k] <= xh_eff[k-1];
            end
            yh_reg[0] <= y_next;
            for (int k = 1; k < OUT_HIST; k++)
            begin
                yh_reg[k] <= yh_eff[k-1];
            end
        end
    end

    // Hold the result until the next advance
    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            y_reg <= y_next;
        end
    end

    assign sample_out = y_reg;

endmodule

FILE: tb/tb_iir_direct_form_one_filter.sv
`timescale 1ns / 1ps
// Self-checking testbench for the direct form I IIR filter: a clocked driver and monitor
// around a bit-exact filter predictor, with random idling on both stream channels.
// Depends on iirdf1_pkg, iirdf1_if and the iir_direct_form_one_filter top level.
module tb_iir_direct_form_one_filter;
    import iirdf1_pkg::*;

    localparam int SW              = SAMPLE_WIDTH_DEF;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 6;
    localparam int WATCHDOG_LIMIT  = 4000;

    typedef logic signed [SW-1:0] sample_t;

    typedef struct packed {
        sample_t sample;
        logic    restart;
    } sample_item_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                       cfg_we;
    logic [REG_INDEX_WIDTH-1:0] cfg_index;
    logic [COEF_WIDTH-1:0]      cfg_data;

    iirdf1_in_if  #(.SAMPLE_WIDTH(SW)) din_if ();
    iirdf1_out_if #(.SAMPLE_WIDTH(SW)) dout_if ();

    iir_direct_form_one_filter #(
        .SAMPLE_WIDTH(SW),
        .FF_TAPS     (FF_TAPS_DEF),
        .FB_TAPS     (FB_TAPS_DEF)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .din      (din_if),
        .dout     (dout_if),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #6 clk = ~clk;

    // Filter state mirrored by the predictor
    coef_t   coef_model [NUM_REGS];
    coef_t   next_coefs [NUM_REGS];
    sample_t x_hist [3];
    sample_t y_hist [4];

    sample_item_t pending_samples [$];
    sample_t      expected_outputs [$];

    int   error_count = 0;
    int   send_gap_left;
    int   recv_stall_left;
    int   hold_left;
    int   quiet_cycles;
    logic bursts_on;
    logic hold_start;

    task automatic report_mismatch(string what, sample_t got, sample_t want);
        $display("MISMATCH at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Compute y[n] from the mirrored state and advance both histories
    function automatic sample_t filter_step(sample_t x, logic restart);
        longint acc;
        longint y;
        longint smax;
        longint smin;
        smax = (longint'(1) <<< (SW - 1)) - 1;
        smin = -smax - 1;
        if (restart)
        begin
            foreach (x_hist[k]) x_hist[k] = '0;
            foreach (y_hist[k]) y_hist[k] = '0;
        end
        acc = longint'(coef_model[REG_FF_COEF_0]) * longint'(x);
        for (int k = 1; k < FF_TAPS_DEF && k <= 3; k++)
            acc += longint'(coef_model[k]) * longint'(x_hist[k-1]);
        for (int k = 1; k <= FB_TAPS_DEF && k <= 4; k++)
            acc -= longint'(coef_model[3+k]) * longint'(y_hist[k-1]);
        // Round half up, then floor
        y = (acc + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
        if (y > smax)
            y = smax;
        if (y < smin)
            y = smin;
        for (int k = 2; k > 0; k--)
            x_hist[k] = x_hist[k-1];
        x_hist[0] = x;
        for (int k = 3; k > 0; k--)
            y_hist[k] = y_hist[k-1];
        y_hist[0] = sample_t'(y);
        return sample_t'(y);
    endfunction

    function automatic coef_t pick_coef(int unsigned kind, bit feedback);
        int v;
        v = 0;
        case (kind)
            0: v = int'($urandom_range(0, (1 << COEF_WIDTH) - 1)) - (1 << (COEF_WIDTH - 1));
            1:
            begin
                if (feedback)
                    v = int'($urandom_range(0, 4095)) - 2048;
                else
                    v = int'($urandom_range(0, 32767)) - 16384;
            end
            2:
            begin
                case ($urandom_range(0, 4))
                    0: v = (1 << (COEF_WIDTH - 1)) - 1;
                    1: v = -(1 << (COEF_WIDTH - 1));
                    2: v = 0;
                    3: v = int'(COEF_ONE);
                    default: v = -int'(COEF_ONE);
                endcase
            end
            default:
            begin
                if (!feedback)
                    v = int'($urandom_range(0, (1 << COEF_WIDTH) - 1)) - (1 << (COEF_WIDTH - 1));
            end
        endcase
        return coef_t'(v);
    endfunction

    function automatic sample_t pick_sample();
        int v;
        case ($urandom_range(0, 9))
            0: v = $urandom_range(0, 1) ? 32767 : -32768;
            1, 2, 3: v = int'($urandom_range(0, 1023)) - 512;
            default: v = int'($urandom_range(0, 65535)) - 32768;
        endcase
        return sample_t'(v);
    endfunction

    task automatic queue_sample(int value, bit restart);
        sample_item_t item;
        item.sample  = sample_t'(value);
        item.restart = restart;
        pending_samples.insert(pending_samples.size(), item);
    endtask

    // Write next_coefs into all registers, one per cycle, while the filter is idle
    task automatic load_coefs();
        reg_index_t r;
        r = REG_FF_COEF_0;
        repeat (NUM_REGS)
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= r;
            cfg_data  <= next_coefs[r];
            coef_model[r] = next_coefs[r];
            r = r.next();
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_coefs(int b0, int b1, int b2, int b3, int a1, int a2, int a3, int a4);
        next_coefs[REG_FF_COEF_0] = coef_t'(b0);
        next_coefs[REG_FF_COEF_1] = coef_t'(b1);
        next_coefs[REG_FF_COEF_2] = coef_t'(b2);
        next_coefs[REG_FF_COEF_3] = coef_t'(b3);
        next_coefs[REG_FB_COEF_1] = coef_t'(a1);
        next_coefs[REG_FB_COEF_2] = coef_t'(a2);
        next_coefs[REG_FB_COEF_3] = coef_t'(a3);
        next_coefs[REG_FB_COEF_4] = coef_t'(a4);
        load_coefs();
    endtask

    // Hold until every queued sample is sent and every result is back;
    // check on the falling edge so the handshake signals have settled
    task automatic wait_drained();
        @(negedge clk);
        while (pending_samples.size() != 0 || din_if.valid || expected_outputs.size() != 0
               || dout_if.valid)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Driver: offer pending samples, predict each one on its transfer
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            din_if.valid  <= 1'b0;
            send_gap_left <= 0;
        end
        else
        begin
            if (din_if.valid && din_if.ready)
                expected_outputs.insert(expected_outputs.size(),
                                        filter_step(din_if.sample_in, din_if.restart));
            if (!din_if.valid || din_if.ready)
            begin
                if (send_gap_left != 0)
                begin
                    din_if.valid  <= 1'b0;
                    send_gap_left <= send_gap_left - 1;
                end
                else if (bursts_on && $urandom_range(0, 7) == 0)
                begin
                    din_if.valid  <= 1'b0;
                    send_gap_left <= $urandom_range(0, 6);
                end
                else if (pending_samples.size() != 0)
                begin
                    sample_item_t item;
                    item = pending_samples.pop_front();
                    din_if.valid     <= 1'b1;
                    din_if.sample_in <= item.sample;
                    din_if.restart   <= item.restart;
                end
                else
                begin
                    din_if.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            dout_if.ready   <= 1'b0;
            recv_stall_left <= 0;
            hold_left       <= 0;
        end
        else if (hold_left != 0)
        begin
            dout_if.ready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (hold_start)
        begin
            dout_if.ready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
        end
        else if (recv_stall_left != 0)
        begin
            dout_if.ready   <= 1'b0;
            recv_stall_left <= recv_stall_left - 1;
        end
        else if (bursts_on && $urandom_range(0, 7) == 0)
        begin
            dout_if.ready   <= 1'b0;
            recv_stall_left <= $urandom_range(0, 6);
        end
        else
        begin
            dout_if.ready <= 1'b1;
        end
    end

    // Monitor: compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && dout_if.valid && dout_if.ready)
        begin
            if (expected_outputs.size() == 0)
                report_mismatch("result with nothing expected", dout_if.sample_out, '0);
            else
            begin
                sample_t want;
                want = expected_outputs.pop_front();
                if (dout_if.sample_out !== want)
                    report_mismatch("sample_out", dout_if.sample_out, want);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready)
            || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int unsigned kind;
        rst_n            = 1'b0;
        din_if.valid     = 1'b0;
        din_if.sample_in = '0;
        din_if.restart   = 1'b0;
        dout_if.ready    = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        bursts_on        = 1'b1;
        hold_start       = 1'b0;
        quiet_cycles     = 0;
        foreach (coef_model[k]) coef_model[k] = '0;
        coef_model[REG_FF_COEF_0] = COEF_ONE;
        foreach (x_hist[k]) x_hist[k] = '0;
        foreach (y_hist[k]) y_hist[k] = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pass-through after reset: sample extremes and a restart
        queue_sample(32767, 0);
        queue_sample(-32768, 0);
        queue_sample(0, 0);
        queue_sample(-1, 0);
        queue_sample(1, 0);
        queue_sample(12345, 1);
        queue_sample(-2, 0);
        wait_drained();

        // Half-LSB sums round toward plus infinity
        set_coefs(8192, 0, 0, 0, 0, 0, 0, 0);
        queue_sample(1, 0);
        queue_sample(-1, 0);
        queue_sample(3, 0);
        queue_sample(-3, 0);
        wait_drained();

        // Largest coefficients: saturate high and low
        set_coefs(131071, 131071, 131071, 131071, 131071, 131071, 131071, 131071);
        queue_sample(32767, 1);
        queue_sample(32767, 0);
        queue_sample(-32768, 0);
        queue_sample(100, 0);
        wait_drained();

        // Smallest coefficients
        set_coefs(-131072, -131072, -131072, -131072, -131072, -131072, -131072, -131072);
        queue_sample(-32768, 1);
        queue_sample(32767, 0);
        queue_sample(-1, 0);
        queue_sample(0, 1);
        wait_drained();

        // Runaway feedback clamps and the clamped value is fed back
        set_coefs(16384, 0, 0, 0, -131072, 0, 0, 0);
        queue_sample(1000, 1);
        queue_sample(1000, 0);
        queue_sample(1000, 0);
        queue_sample(-32768, 0);
        wait_drained();

        // Random phases, each with its own coefficient set
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            kind = (p == NUM_PHASES - 1) ? 1 : p % 4;
            foreach (next_coefs[k])
                next_coefs[k] = pick_coef(kind, k >= int'(REG_FB_COEF_1));
            load_coefs();
            if (p == NUM_PHASES - 1)
                bursts_on <= 1'b0;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                queue_sample(int'(pick_sample()), $urandom_range(0, 39) == 0);
                // Pause the sender until the filter has drained
                if (p == 1 && i == ITEMS_PER_PHASE / 2)
                    wait_drained();
            end
            // Long receiver hold-off while the sender keeps offering
            if (p == 2)
            begin
                @(posedge clk);
                hold_start <= 1'b1;
                @(posedge clk);
                hold_start <= 1'b0;
            end
            wait_drained();
        end

        if (expected_outputs.size() != 0)
            report_mismatch("results never arrived", '0, expected_outputs[0]);

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
src/iirdf1_pkg.sv
src/iirdf1_if.sv
src/iirdf1_core.sv
src/iir_direct_form_one_filter.sv
tb/tb_iir_direct_form_one_filter.sv
